### hdl/shs_pkg.sv
// Package for the stepper homing sequencer.
// Holds the period width, register indexes, phase codes, the result record and the period saturation function.
// No dependencies.
`default_nettype none

package shs_pkg;

	localparam int PERIOD_BITS = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [31:0] PERIOD_MAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAST_HALF  = 3'd0,
		REG_SLOW_HALF  = 3'd1,
		REG_RETRACT    = 3'd2,
		REG_SETTLE     = 3'd3,
		REG_START_DIR  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_FAST    = 3'd1,
		PH_RETRACT = 3'd2,
		PH_SLOW    = 3'd3,
		PH_FINAL   = 3'd4
	} phase_t;

	typedef struct packed {
		logic       step_level;
		logic       dir_level;
		logic [2:0] phase;
		logic       settling;
		logic       home_mark;
		logic       done_res;
	} res_t;

	function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [19:0] p);
		logic [31:0] w;
		w = 32'(p);
		if (w > PERIOD_MAX) begin
			w = PERIOD_MAX;
		end
		if (w == 32'd0) begin
			w = 32'd1;
		end
		return w[PERIOD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### hdl/stepper_homing_sequencer.sv
// Top level of the stepper homing sequencer.
// Depends on shs_pkg for the period width, codes and the result record.
//
// Usage: each input transaction is either a start request (kind = 1) or one
// motor-clock tick (kind = 0) carrying the sampled minimum limit switch level.
// Every input transaction produces exactly one result transaction carrying the
// step and direction pin levels, the phase, the settling flag and the one-shot
// home and done flags.
// Throughput is one transaction per cycle while in_stall is low: the sequencer
// state and the result are updated by a single pass of logic at the accepting
// edge. Each result is registered and shown at out_valid from the main entry,
// passing through the skid entry first when out_stall holds the main entry.
// A two-entry result buffer separates the channels: when out_stall is raised
// one more input is still taken into the skid entry, and in_stall rises only
// when both entries are full.
// Reset (arst_n low) puts the sequencer in idle, empties the result buffer
// and loads the register reset values 500, 5000, 100, 1000 and 0.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// the next half step or phase that uses them; unknown indexes are ignored.
`default_nettype none

module stepper_homing_sequencer
	import shs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic                  kind,
	input  wire logic                  limit_released,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic                  step_level,
	output      logic                  dir_level,
	output      logic [2:0]            phase,
	output      logic                  settling,
	output      logic                  home_mark,
	output      logic                  done_res
);

	logic [19:0] fast_half_q;
	logic [19:0] slow_half_q;
	logic [15:0] retract_q;
	logic [23:0] settle_cfg_q;
	logic        start_dir_q;

	phase_t                 phase_q, phase_d;
	logic                   dir_q, dir_d;
	logic [PERIOD_BITS-1:0] half_q, half_d;
	logic                   high_q, high_d;
	logic [15:0]            steps_q, steps_d;
	logic [23:0]            settle_q, settle_d;
	res_t                   res_d;

	res_t main_q, skid_q;
	logic main_v_q, skid_v_q;
	logic accept, take;

	assign in_stall = skid_v_q;
	assign accept   = in_valid && !skid_v_q;
	assign take     = main_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_half_q  <= 20'd500;
			slow_half_q  <= 20'd5000;
			retract_q    <= 16'd100;
			settle_cfg_q <= 24'd1000;
			start_dir_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAST_HALF: fast_half_q  <= cfg_data[19:0];
				REG_SLOW_HALF: slow_half_q  <= cfg_data[19:0];
				REG_RETRACT:   retract_q    <= cfg_data[15:0];
				REG_SETTLE:    settle_cfg_q <= cfg_data;
				REG_START_DIR: start_dir_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic go;
		logic rev;
		phase_t rev_to;
		logic [PERIOD_BITS-1:0] per;

		phase_d  = phase_q;
		dir_d    = dir_q;
		half_d   = half_q;
		high_d   = high_q;
		steps_d  = steps_q;
		settle_d = settle_q;
		res_d    = '0;
		go       = 1'b0;
		rev      = 1'b0;
		rev_to   = PH_RETRACT;
		per      = sat_period((phase_q == PH_FAST) ? fast_half_q : slow_half_q);

		if (kind) begin
			if (phase_q == PH_IDLE) begin
				phase_d  = PH_FAST;
				dir_d    = start_dir_q;
				half_d   = '0;
				high_d   = 1'b0;
				steps_d  = '0;
				settle_d = '0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (settle_q != 24'd0) begin
				settle_d       = settle_q - 24'd1;
				res_d.settling = 1'b1;
			end else begin
				if (half_q == '0) begin
					if (phase_q == PH_FAST || phase_q == PH_SLOW) begin
						if (limit_released) begin
							go = 1'b1;
						end else begin
							rev = 1'b1;
							if (phase_q == PH_SLOW) begin
								res_d.home_mark = 1'b1;
								rev_to          = PH_FINAL;
							end
						end
					end else if (steps_q != 16'd0) begin
						steps_d = steps_q - 16'd1;
						go      = 1'b1;
					end else if (phase_q == PH_RETRACT) begin
						rev    = 1'b1;
						rev_to = PH_SLOW;
					end else begin
						phase_d        = PH_IDLE;
						res_d.done_res = 1'b1;
					end
				end
				if (rev) begin
					dir_d          = !dir_q;
					settle_d       = settle_cfg_q;
					steps_d        = retract_q;
					phase_d        = rev_to;
					res_d.settling = (settle_cfg_q != 24'd0);
				end
				if (go) begin
					res_d.step_level = 1'b0;
					half_d = per - PERIOD_BITS'(1);
					high_d = (half_d == '0);
					if (half_d == '0) begin
						half_d = per;
					end
				end else if (half_q != '0) begin
					res_d.step_level = high_q;
					half_d = half_q - PERIOD_BITS'(1);
					if (half_d == '0) begin
						if (!high_q) begin
							high_d = 1'b1;
							half_d = per;
						end else begin
							high_d = 1'b0;
						end
					end
				end
			end
		end
		res_d.dir_level = dir_d;
		res_d.phase     = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			dir_q    <= 1'b0;
			half_q   <= '0;
			high_q   <= 1'b0;
			steps_q  <= '0;
			settle_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			dir_q    <= dir_d;
			half_q   <= half_d;
			high_q   <= high_d;
			steps_q  <= steps_d;
			settle_q <= settle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (take && skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (take || !main_v_q) begin
				main_v_q <= accept;
			end else if (accept) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_v_q) begin
			main_q <= skid_q;
		end else if ((take || !main_v_q) && accept) begin
			main_q <= res_d;
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign out_valid  = main_v_q;
	assign step_level = main_q.step_level;
	assign dir_level  = main_q.dir_level;
	assign phase      = main_q.phase;
	assign settling   = main_q.settling;
	assign home_mark  = main_q.home_mark;
	assign done_res   = main_q.done_res;

endmodule

`default_nettype wire
